// ===== hdl/assert_macros.svh =====
// Assertion helper macros shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked on every rising clk edge, disabled in reset.
`define ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication checked on every rising clk edge, disabled in reset.
`define ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// ===== hdl/aes_pkg.sv =====
// ----------------------------------------------------------------------------
// aes_pkg
// Shared constants and byte functions for the AES-128 cipher pipeline.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
package aes_pkg;

    localparam int ROUNDS = 10;

    localparam logic [0:0] OP_ENC = 1'b0;
    localparam logic [0:0] OP_DEC = 1'b1;

    localparam int REG_KEY_HIGH = 0;
    localparam int REG_KEY_LOW  = 1;

    localparam logic [7:0] SBOX [256] = '{
        8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
        8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
        8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
        8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
        8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
        8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
        8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
        8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
        8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
        8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
        8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
        8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
        8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
        8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
        8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
        8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
    };

    localparam logic [7:0] ISBOX [256] = '{
        8'h52,8'h09,8'h6a,8'hd5,8'h30,8'h36,8'ha5,8'h38,8'hbf,8'h40,8'ha3,8'h9e,8'h81,8'hf3,8'hd7,8'hfb,
        8'h7c,8'he3,8'h39,8'h82,8'h9b,8'h2f,8'hff,8'h87,8'h34,8'h8e,8'h43,8'h44,8'hc4,8'hde,8'he9,8'hcb,
        8'h54,8'h7b,8'h94,8'h32,8'ha6,8'hc2,8'h23,8'h3d,8'hee,8'h4c,8'h95,8'h0b,8'h42,8'hfa,8'hc3,8'h4e,
        8'h08,8'h2e,8'ha1,8'h66,8'h28,8'hd9,8'h24,8'hb2,8'h76,8'h5b,8'ha2,8'h49,8'h6d,8'h8b,8'hd1,8'h25,
        8'h72,8'hf8,8'hf6,8'h64,8'h86,8'h68,8'h98,8'h16,8'hd4,8'ha4,8'h5c,8'hcc,8'h5d,8'h65,8'hb6,8'h92,
        8'h6c,8'h70,8'h48,8'h50,8'hfd,8'hed,8'hb9,8'hda,8'h5e,8'h15,8'h46,8'h57,8'ha7,8'h8d,8'h9d,8'h84,
        8'h90,8'hd8,8'hab,8'h00,8'h8c,8'hbc,8'hd3,8'h0a,8'hf7,8'he4,8'h58,8'h05,8'hb8,8'hb3,8'h45,8'h06,
        8'hd0,8'h2c,8'h1e,8'h8f,8'hca,8'h3f,8'h0f,8'h02,8'hc1,8'haf,8'hbd,8'h03,8'h01,8'h13,8'h8a,8'h6b,
        8'h3a,8'h91,8'h11,8'h41,8'h4f,8'h67,8'hdc,8'hea,8'h97,8'hf2,8'hcf,8'hce,8'hf0,8'hb4,8'he6,8'h73,
        8'h96,8'hac,8'h74,8'h22,8'he7,8'had,8'h35,8'h85,8'he2,8'hf9,8'h37,8'he8,8'h1c,8'h75,8'hdf,8'h6e,
        8'h47,8'hf1,8'h1a,8'h71,8'h1d,8'h29,8'hc5,8'h89,8'h6f,8'hb7,8'h62,8'h0e,8'haa,8'h18,8'hbe,8'h1b,
        8'hfc,8'h56,8'h3e,8'h4b,8'hc6,8'hd2,8'h79,8'h20,8'h9a,8'hdb,8'hc0,8'hfe,8'h78,8'hcd,8'h5a,8'hf4,
        8'h1f,8'hdd,8'ha8,8'h33,8'h88,8'h07,8'hc7,8'h31,8'hb1,8'h12,8'h10,8'h59,8'h27,8'h80,8'hec,8'h5f,
        8'h60,8'h51,8'h7f,8'ha9,8'h19,8'hb5,8'h4a,8'h0d,8'h2d,8'he5,8'h7a,8'h9f,8'h93,8'hc9,8'h9c,8'hef,
        8'ha0,8'he0,8'h3b,8'h4d,8'hae,8'h2a,8'hf5,8'hb0,8'hc8,8'heb,8'hbb,8'h3c,8'h83,8'h53,8'h99,8'h61,
        8'h17,8'h2b,8'h04,8'h7e,8'hba,8'h77,8'hd6,8'h26,8'he1,8'h69,8'h14,8'h63,8'h55,8'h21,8'h0c,8'h7d
    };

    localparam logic [7:0] RCON [ROUNDS] = '{
        8'h01, 8'h02, 8'h04, 8'h08, 8'h10, 8'h20, 8'h40, 8'h80, 8'h1b, 8'h36
    };

    function automatic logic [7:0] xt(input logic [7:0] a);
        xt = {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
    endfunction

    // One AES column, bytes r0..r3 at [31:24]..[7:0].
    function automatic logic [31:0] mix_col(input logic [31:0] c);
        logic [7:0] a [4];
        logic [31:0] o;
        for (int r = 0; r < 4; r++) a[r] = c[31-8*r -: 8];
        for (int r = 0; r < 4; r++)
            o[31-8*r -: 8] = xt(a[r]) ^ xt(a[(r+1)%4]) ^ a[(r+1)%4]
                             ^ a[(r+2)%4] ^ a[(r+3)%4];
        mix_col = o;
    endfunction

    function automatic logic [31:0] inv_mix_col(input logic [31:0] c);
        logic [7:0] a [4];
        logic [7:0] x2 [4];
        logic [7:0] x4 [4];
        logic [7:0] x8 [4];
        logic [31:0] o;
        for (int r = 0; r < 4; r++)
        begin
            a[r]  = c[31-8*r -: 8];
            x2[r] = xt(a[r]);
            x4[r] = xt(x2[r]);
            x8[r] = xt(x4[r]);
        end
        // 14 = 8^4^2, 11 = 8^2^1, 13 = 8^4^1, 9 = 8^1
        for (int r = 0; r < 4; r++)
            o[31-8*r -: 8] = (x8[r] ^ x4[r] ^ x2[r])
                ^ (x8[(r+1)%4] ^ x2[(r+1)%4] ^ a[(r+1)%4])
                ^ (x8[(r+2)%4] ^ x4[(r+2)%4] ^ a[(r+2)%4])
                ^ (x8[(r+3)%4] ^ a[(r+3)%4]);
        inv_mix_col = o;
    endfunction

    function automatic logic [127:0] mix_all(input logic [127:0] s, input logic inv);
        logic [127:0] o;
        for (int c = 0; c < 4; c++)
            o[127-32*c -: 32] = inv ? inv_mix_col(s[127-32*c -: 32])
                                    : mix_col(s[127-32*c -: 32]);
        mix_all = o;
    endfunction

    // SubBytes+ShiftRows or inverse; state byte i at [127-8i -: 8].
    function automatic logic [127:0] sub_shift(input logic [127:0] s, input logic inv);
        logic [127:0] o;
        for (int c = 0; c < 4; c++)
            for (int r = 0; r < 4; r++)
                if (inv)
                    o[127-8*(4*c+r) -: 8] = ISBOX[s[127-8*(4*((c+4-r)%4)+r) -: 8]];
                else
                    o[127-8*(4*c+r) -: 8] = SBOX[s[127-8*(4*((c+r)%4)+r) -: 8]];
        sub_shift = o;
    endfunction

    // Next AES-128 round key from the previous one.
    function automatic logic [127:0] next_key(input logic [127:0] k, input logic [7:0] rc);
        logic [31:0] w [4];
        logic [31:0] t;
        logic [127:0] o;
        for (int i = 0; i < 4; i++) w[i] = k[127-32*i -: 32];
        t = {SBOX[w[3][23:16]] ^ rc, SBOX[w[3][15:8]], SBOX[w[3][7:0]], SBOX[w[3][31:24]]};
        o[127:96] = w[0] ^ t;
        o[95:64]  = w[1] ^ w[0] ^ t;
        o[63:32]  = w[2] ^ w[1] ^ w[0] ^ t;
        o[31:0]   = w[3] ^ w[2] ^ w[1] ^ w[0] ^ t;
        next_key = o;
    endfunction

endpackage
`default_nettype wire

// ===== hdl/aes128_block_cipher.sv =====
// ----------------------------------------------------------------------------
// aes128_block_cipher
// AES-128 encrypt/decrypt, fully unrolled round pipeline.
// ----------------------------------------------------------------------------
// Pipeline: key-add stage plus ten round stages, output taken straight from
// the last stage. Throughput: one request per cycle while in_stall is low;
// the whole pipeline freezes while out_stall holds a valid result.
// Input stalls after reset and after each key write while the round-key
// table refills one round per cycle.
// Reset clears key_reg to zero and all stage valid bits.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
module aes128_block_cipher
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic        op,
    input  wire logic [63:0] block_high,
    input  wire logic [63:0] block_low,
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic [63:0]      result_high,
    output logic [63:0]      result_low,
    input  wire logic        cfg_we,
    input  wire logic        cfg_index,
    input  wire logic [63:0] cfg_data
);

    localparam int R = aes_pkg::ROUNDS;

    logic [127:0] key_reg;
    // rk_reg[i]: encryption round key i, built one round per cycle after a write
    logic [127:0] rk_reg [R+1];
    // dk_reg[i]: InvMixColumns of middle round keys for the equivalent inverse
    logic [127:0] dk_reg [R+1];
    // Cycles left until the key table has caught up with key_reg
    logic [3:0]   key_wait_reg;
    logic         key_ready;

    logic [R:0]   v_reg;
    logic [127:0] s_reg [R+1];
    logic         op_reg [R+1];
    logic         adv;

    assign adv       = !(v_reg[R] && out_stall);
    assign key_ready = (key_wait_reg == 4'd0);
    assign in_stall  = !adv || !key_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_reg      <= '0;
            key_wait_reg <= 4'(R + 1);
        end
        else if (cfg_we)
        begin
            if (cfg_index == 1'(aes_pkg::REG_KEY_HIGH))
                key_reg[127:64] <= cfg_data;
            else
                key_reg[63:0] <= cfg_data;
            key_wait_reg <= 4'(R + 1);
        end
        else if (!key_ready)
            key_wait_reg <= key_wait_reg - 4'd1;
    end

    // Key table: a ripple of registers, each round depends on the one before.
    always_ff @(posedge clk)
    begin
        rk_reg[0] <= key_reg;
        dk_reg[0] <= rk_reg[0];
        for (int i = 1; i <= R; i++)
        begin
            rk_reg[i] <= aes_pkg::next_key(rk_reg[i-1], aes_pkg::RCON[i-1]);
            dk_reg[i] <= (i == R) ? rk_reg[i] : aes_pkg::mix_all(rk_reg[i], 1'b1);
        end
    end

    // Stage 0 does the whitening add; stages 1..R do one round each.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v_reg <= '0;
        else if (adv)
            v_reg <= {v_reg[R-1:0], in_valid && key_ready};
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s_reg[0]  <= {block_high, block_low}
                         ^ ((op == aes_pkg::OP_DEC) ? rk_reg[R] : rk_reg[0]);
            op_reg[0] <= op;
            for (int i = 1; i <= R; i++)
            begin
                logic [127:0] t;
                t = aes_pkg::sub_shift(s_reg[i-1], op_reg[i-1]);
                if (i != R)
                    t = aes_pkg::mix_all(t, op_reg[i-1]);
                s_reg[i]  <= t ^ (op_reg[i-1] ? dk_reg[R-i] : rk_reg[i]);
                op_reg[i] <= op_reg[i-1];
            end
        end
    end

    assign out_valid   = v_reg[R];
    assign result_high = s_reg[R][127:64];
    assign result_low  = s_reg[R][63:0];

    `ASSERT_NEXT(a_hold, out_valid && out_stall, out_valid && $stable(result_high))
    `ASSERT_IMPL(a_stall, in_stall && key_ready, out_valid && out_stall)
    `ASSERT_NEXT(a_move, !in_stall && in_valid, v_reg[0])
    `ASSERT_NEXT(a_key, cfg_we, in_stall)

endmodule
`default_nettype wire
